[design/ctw_pkg.sv]
package ctw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0]  COLOR_RESET  = 8'h07;
	localparam logic [15:0] CLEAR_WORD   = 16'h0700;
	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam int          CELL_W       = 16;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [4:0]  cursor_row_now;
		logic [6:0]  cursor_col_now;
		logic [15:0] cell_data;
		logic        scrolled;
	} rsp_t;

endpackage

[design/ctw_ram.sv]
module ctw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/text_console_writer_top.sv]
// channel  | direction | payload        | handshake
// cmd      | in        | ctw_pkg::cmd_t | cmd_valid / cmd_stall
// rsp      | out       | ctw_pkg::rsp_t | rsp_valid / rsp_stall
// color    | in        | 8-bit register | color_we, no stall
// Put without scroll passes ST_PUT, read in range ST_READ, clear ST_FILL, then ST_DONE loads the
// result; other ops go straight to ST_DONE. A put with a scroll pending first passes ST_SHIFT
// and ST_ZERO: one pass of the single RAM write port over the shifted rows and the blank last row.
// Clear writes one cell per cycle.
// After reset the store is zeroed in ST_INIT; cmd_stall is high meanwhile.
// One transaction at a time; the next one is taken while the result register is held.
module text_console_writer_top #(
	parameter int COLUMNS = ctw_pkg::COLUMNS_DEF,
	parameter int ROWS    = ctw_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  ctw_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ctw_pkg::rsp_t rsp,
	input  logic          color_we,
	input  logic [7:0]    color_wdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(CELLS + 1);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLUMNS);

	typedef enum logic [7:0] {
		ST_INIT  = 8'b00000001,
		ST_IDLE  = 8'b00000010,
		ST_SHIFT = 8'b00000100,
		ST_ZERO  = 8'b00001000,
		ST_FILL  = 8'b00010000,
		ST_PUT   = 8'b00100000,
		ST_READ  = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;

	state_t                       state_q;
	ctw_pkg::cmd_t                cmd_q;
	logic [RW-1:0]                row_q;
	logic [CW-1:0]                col_q;
	logic [PW-1:0]                pos_q;
	logic [7:0]                   color_q;
	logic [AW-1:0]                addr_q;
	logic                         scrolled_q;
	logic [ctw_pkg::CELL_W-1:0]   data_q;
	logic                         wr_pend_s1;
	logic [AW-1:0]                waddr_s1;
	logic                         rsp_valid_q;
	ctw_pkg::rsp_t                rsp_q;

	logic                         cmd_take;
	logic                         rsp_free;
	logic                         addr_last;
	logic                         is_nl;
	logic                         idx_ok;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [ctw_pkg::CELL_W-1:0]   ram_wdata;
	logic [AW-1:0]                ram_raddr;
	logic [ctw_pkg::CELL_W-1:0]   ram_rdata;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign addr_last = (addr_q == AW'(CELLS - 1));
	assign is_nl     = (cmd_q.char_code == ctw_pkg::NEWLINE_CODE);
	assign idx_ok    = (int'(cmd.cell_index) < CELLS);

	// shift: read row below, write it back one row up on the next cycle
	assign ram_raddr = (state_q == ST_SHIFT) ? AW'(addr_q + AW'(COLUMNS))
	                                         : AW'(cmd.cell_index);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		if (wr_pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = ram_rdata;
		end else begin
			unique case (state_q)
				ST_INIT, ST_ZERO: begin
					ram_we = 1'b1;
				end
				ST_FILL: begin
					ram_we    = 1'b1;
					ram_wdata = ctw_pkg::CLEAR_WORD;
				end
				ST_PUT: begin
					ram_we    = !is_nl;
					ram_waddr = AW'(pos_q);
					ram_wdata = {color_q, cmd_q.char_code};
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	ctw_ram #(
		.WIDTH(ctw_pkg::CELL_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= ctw_pkg::COLOR_RESET;
		end else if (color_we) begin
			color_q <= color_wdata;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= addr_q;
		if (cmd_take) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			addr_q      <= '0;
			scrolled_q  <= 1'b0;
			data_q      <= '0;
			wr_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			wr_pend_s1  <= (state_q == ST_SHIFT);
			rsp_valid_q <= ((state_q == ST_DONE) && rsp_free) || (rsp_valid_q && rsp_stall);
			unique case (state_q)
				ST_INIT: begin
					addr_q <= addr_last ? '0 : AW'(addr_q + 1'b1);
					if (addr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_take) begin
						scrolled_q <= 1'b0;
						data_q     <= '0;
						addr_q     <= '0;
						unique case (ctw_pkg::op_t'(cmd.operation))
							ctw_pkg::OP_PUT: begin
								state_q <= (row_q == RW'(ROWS)) ? ST_SHIFT : ST_PUT;
							end
							ctw_pkg::OP_CLEAR: begin
								state_q <= ST_FILL;
							end
							ctw_pkg::OP_READ: begin
								state_q <= idx_ok ? ST_READ : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					addr_q <= AW'(addr_q + 1'b1);
					if (addr_q == AW'(CELLS - COLUMNS - 1)) begin
						state_q <= ST_ZERO;
					end
				end
				ST_ZERO: begin
					// the last shifted word owns the write port on the first cycle
					if (!wr_pend_s1) begin
						addr_q <= AW'(addr_q + 1'b1);
						if (addr_last) begin
							row_q      <= RW'(ROWS - 1);
							pos_q      <= PW'(pos_q - PW'(COLUMNS));
							scrolled_q <= 1'b1;
							state_q    <= ST_PUT;
						end
					end
				end
				ST_FILL: begin
					addr_q <= AW'(addr_q + 1'b1);
					if (addr_last) begin
						row_q   <= '0;
						col_q   <= '0;
						pos_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_PUT: begin
					if (is_nl) begin
						row_q <= RW'(row_q + 1'b1);
						col_q <= '0;
						pos_q <= PW'(pos_q - PW'(col_q) + PW'(COLUMNS));
					end else begin
						pos_q <= PW'(pos_q + 1'b1);
						if (col_q == CW'(COLUMNS - 1)) begin
							row_q <= RW'(row_q + 1'b1);
							col_q <= '0;
						end else begin
							col_q <= CW'(col_q + 1'b1);
						end
					end
					state_q <= ST_DONE;
				end
				ST_READ: begin
					data_q  <= ram_rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_q.cursor_position       <= 11'(pos_q);
						rsp_q.cursor_row_now        <= 5'(row_q);
						rsp_q.cursor_col_now        <= 7'(col_q);
						rsp_q.cell_data             <= data_q;
						rsp_q.scrolled              <= scrolled_q;
						state_q                     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) <= ROWS) && (int'(col_q) < COLUMNS))
		else $error("cursor out of range");

	a_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("linear cursor out of step with row and column");

	a_shift_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (row_q == RW'(ROWS)))
		else $error("scroll without a pending row");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");
`endif

endmodule
